// ===== rtl/clm_pkg.sv =====
// Shared types and codes for the circular list manager.
// No dependencies; clm_ctrl, the top level and the checker refer to this package.
package clm_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int COUNT_W      = 9;

  localparam logic [2:0] REQ_INS_HEAD  = 3'd0;
  localparam logic [2:0] REQ_INS_AFTER = 3'd1;
  localparam logic [2:0] REQ_INS_TAIL  = 3'd2;
  localparam logic [2:0] REQ_DEL_HEAD  = 3'd3;
  localparam logic [2:0] REQ_DEL_KEY   = 3'd4;
  localparam logic [2:0] REQ_DEL_TAIL  = 3'd5;
  localparam logic [2:0] REQ_SEARCH    = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [2:0]               req_type;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic                     found;
    logic [COUNT_W-1:0]       node_count;
    logic signed [DATA_W-1:0] data_sum;
  } rsp_t;

endpackage

// ===== rtl/clm_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
// No dependencies; used for node data, node links and the free-slot stack.
module clm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/clm_ctrl.sv =====
// Sequencer of the circular list manager: list walk, allocation, linking.
// Depends on clm_pkg; drives the three clm_ram instances in the top level.
module clm_ctrl #(
  parameter int CAPACITY = clm_pkg::CAPACITY_DEF,
  parameter int SLOT_W   = $clog2(CAPACITY)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  clm_pkg::req_t               in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output clm_pkg::rsp_t               out_data,
  output logic                        d_we,
  output logic [SLOT_W-1:0]           d_waddr,
  output logic [clm_pkg::DATA_W-1:0]  d_wdata,
  output logic [SLOT_W-1:0]           n_raddr,
  input  logic [clm_pkg::DATA_W-1:0]  d_rdata,
  output logic                        l_we,
  output logic [SLOT_W-1:0]           l_waddr,
  output logic [SLOT_W-1:0]           l_wdata,
  input  logic [SLOT_W-1:0]           l_rdata,
  output logic                        f_we,
  output logic [SLOT_W-1:0]           f_waddr,
  output logic [SLOT_W-1:0]           f_wdata,
  output logic [SLOT_W-1:0]           f_raddr,
  input  logic [SLOT_W-1:0]           f_rdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_INS1  = 3'd3;
  localparam logic [2:0] S_INS2  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]                 state;
  clm_pkg::req_t              req_q;
  logic [SLOT_W-1:0]          head, tail, cur, prv, hitlink, nslot;
  logic [CNT_W-1:0]           count, fresh, rtop, idx;
  logic [clm_pkg::DATA_W-1:0] sum;
  logic [1:0]                 status_q;
  logic                       found_q;

  logic              hit, last, full, unlinking, after_ins;
  logic [SLOT_W-1:0] alloc_slot;

  always_comb begin
    case (req_q.req_type)
      clm_pkg::REQ_SEARCH, clm_pkg::REQ_INS_AFTER, clm_pkg::REQ_DEL_KEY:
        hit = (d_rdata == req_q.key);
      clm_pkg::REQ_DEL_HEAD: hit = 1'b1;
      clm_pkg::REQ_DEL_TAIL: hit = (cur == tail);
      default:               hit = 1'b0;
    endcase
    last       = (idx == count - CNT_W'(1));
    full       = (count == CNT_W'(CAPACITY));
    unlinking  = req_q.req_type inside {clm_pkg::REQ_DEL_HEAD, clm_pkg::REQ_DEL_KEY,
                                        clm_pkg::REQ_DEL_TAIL};
    after_ins  = (req_q.req_type == clm_pkg::REQ_INS_AFTER);
    alloc_slot = (rtop != '0) ? f_rdata : fresh[SLOT_W-1:0];
  end

  // Memory port control.
  always_comb begin
    d_we    = 1'b0;
    d_waddr = alloc_slot;
    d_wdata = req_q.value;
    l_we    = 1'b0;
    l_waddr = alloc_slot;
    l_wdata = l_rdata;
    f_we    = 1'b0;
    f_waddr = rtop[SLOT_W-1:0];
    f_wdata = cur;
    f_raddr = SLOT_W'(rtop - CNT_W'(1));
    n_raddr = head;
    case (state)
      S_WALK: begin
        n_raddr = l_rdata;
        if (hit && unlinking) begin
          f_we    = 1'b1;
          l_we    = (count != CNT_W'(1));
          l_waddr = prv;
          l_wdata = l_rdata;
        end
      end
      S_INS1: begin
        d_we = 1'b1;
        l_we = 1'b1;
        if (after_ins) begin
          l_wdata = hitlink;
        end else if (count == '0) begin
          l_wdata = alloc_slot;
        end else begin
          l_wdata = head;
        end
      end
      S_INS2: begin
        l_we    = 1'b1;
        l_waddr = after_ins ? cur : tail;
        l_wdata = nslot;
      end
      default: begin
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      sum       <= '0;
      fresh     <= '0;
      rtop      <= '0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q    <= in_data;
            found_q  <= 1'b0;
            status_q <= clm_pkg::ST_OK;
            cur      <= head;
            prv      <= tail;
            idx      <= '0;
            case (in_data.req_type)
              clm_pkg::REQ_INS_HEAD, clm_pkg::REQ_INS_TAIL: begin
                if (full) begin
                  status_q <= clm_pkg::ST_FULL;
                  state    <= S_FIN;
                end else begin
                  state <= S_ALLOC;
                end
              end
              clm_pkg::REQ_INS_AFTER, clm_pkg::REQ_DEL_HEAD, clm_pkg::REQ_DEL_KEY,
              clm_pkg::REQ_DEL_TAIL, clm_pkg::REQ_SEARCH: begin
                if (count == '0) begin
                  status_q <= clm_pkg::ST_EMPTY;
                  state    <= S_FIN;
                end else begin
                  state <= S_WALK;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_WALK: begin
          if (hit) begin
            found_q <= !unlinking || (req_q.req_type == clm_pkg::REQ_DEL_KEY);
            if (req_q.req_type == clm_pkg::REQ_SEARCH) begin
              state <= S_FIN;
            end else if (after_ins) begin
              if (full) begin
                status_q <= clm_pkg::ST_FULL;
                state    <= S_FIN;
              end else begin
                hitlink <= l_rdata;
                state   <= S_ALLOC;
              end
            end else begin
              if (count == CNT_W'(1)) begin
                head <= '0;
                tail <= '0;
              end else begin
                if (cur == head) begin
                  head <= l_rdata;
                end
                if (cur == tail) begin
                  tail <= prv;
                end
              end
              sum   <= sum - d_rdata;
              count <= count - CNT_W'(1);
              rtop  <= rtop + CNT_W'(1);
              state <= S_FIN;
            end
          end else if (last) begin
            status_q <= clm_pkg::ST_NOTFOUND;
            state    <= S_FIN;
          end else begin
            prv <= cur;
            cur <= l_rdata;
            idx <= idx + CNT_W'(1);
          end
        end
        S_ALLOC: state <= S_INS1;
        S_INS1: begin
          nslot <= alloc_slot;
          if (rtop != '0) begin
            rtop <= rtop - CNT_W'(1);
          end else begin
            fresh <= fresh + CNT_W'(1);
          end
          sum   <= sum + req_q.value;
          count <= count + CNT_W'(1);
          if (!after_ins && count == '0) begin
            head  <= alloc_slot;
            tail  <= alloc_slot;
            state <= S_FIN;
          end else begin
            state <= S_INS2;
          end
        end
        S_INS2: begin
          if (after_ins) begin
            if (cur == tail) begin
              tail <= nslot;
            end
          end else if (req_q.req_type == clm_pkg::REQ_INS_HEAD) begin
            head <= nslot;
          end else begin
            tail <= nslot;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_data.status     <= status_q;
            out_data.found      <= found_q;
            out_data.node_count <= clm_pkg::COUNT_W'(count);
            out_data.data_sum   <= sum;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/circular_list_manager_top.sv =====
// Top level of the circular list manager: sequencer plus node and free-slot memories.
// Depends on clm_pkg, clm_ram and clm_ctrl.
//
// The block keeps a bounded circular singly linked list of signed 32-bit values and
// handles one request word at a time, returning exactly one result word per request.
// Node data and node links sit in two synchronous memories read at one address per
// cycle; slots freed by deletions go onto a recycle stack in a third memory, and slots
// never yet used are handed out from a counter, so no clearing pass is needed after
// reset. Insert at head or tail allocates a slot, writes the new node with its link and
// then the link that points to it, skipping that last write when the list is empty.
// Search, insert after key, delete by key and delete tail walk the list from the head,
// one node per cycle through the link memory read port, up to the whole list when no
// node matches; an insert after then allocates and links as above. At the default
// capacity of 256 an insert after the last of 255 nodes is the worst case. Delete head
// stops at the first node; a request that finds the list empty, or an insert at head
// or tail into a full list, goes straight to its result. The result register lets a
// finished word wait for the consumer while the next request is accepted and processed.
module circular_list_manager_top #(
  parameter int CAPACITY = clm_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  clm_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output clm_pkg::rsp_t out_data
);

  localparam int SLOT_W = $clog2(CAPACITY);

  logic                       d_we, l_we, f_we;
  logic [SLOT_W-1:0]          d_waddr, l_waddr, f_waddr, n_raddr, f_raddr;
  logic [clm_pkg::DATA_W-1:0] d_wdata, d_rdata;
  logic [SLOT_W-1:0]          l_wdata, l_rdata, f_wdata, f_rdata;

  clm_ctrl #(.CAPACITY(CAPACITY), .SLOT_W(SLOT_W)) u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .d_we(d_we), .d_waddr(d_waddr), .d_wdata(d_wdata),
    .n_raddr(n_raddr), .d_rdata(d_rdata),
    .l_we(l_we), .l_waddr(l_waddr), .l_wdata(l_wdata), .l_rdata(l_rdata),
    .f_we(f_we), .f_waddr(f_waddr), .f_wdata(f_wdata),
    .f_raddr(f_raddr), .f_rdata(f_rdata)
  );

  // Node data and node links are read together at the same slot.
  clm_ram #(.WIDTH(clm_pkg::DATA_W), .DEPTH(CAPACITY)) u_data_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(n_raddr), .rdata(d_rdata)
  );

  clm_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(n_raddr), .rdata(l_rdata)
  );

  // Recycle stack of freed slots.
  clm_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

endmodule

// ===== rtl/clm_checker.sv =====
// Port-level checks for the circular list manager, bound to the top level.
// Depends on clm_pkg and circular_list_manager_top.
module clm_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input clm_pkg::rsp_t out_data
);

  // A waiting result word is not withdrawn.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result word withdrawn while stalled");

  // One request at a time: the block is busy in the cycle after it takes a word.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while the previous one is in progress");

  // A key match is only reported with status ok or store full.
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.found |->
      out_data.status == clm_pkg::ST_OK || out_data.status == clm_pkg::ST_FULL)
    else $error("found flag with an inconsistent status");

  // An empty list sums to zero.
  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.node_count == '0 |-> out_data.data_sum == '0)
    else $error("non-zero sum reported for an empty list");

endmodule

bind circular_list_manager_top clm_checker u_clm_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
